[hdl/clwa_pkg.sv]
// Shared constants, command and status types for the CPU load window averager.
package clwa_pkg;

  // Field widths
  localparam int CNT_IN_W = 64;
  localparam int OUT_W = 15;
  localparam int NUM_OUT = 4;
  localparam int IN_TDATA_W = ((3 * CNT_IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_OUT * OUT_W + 7) / 8) * 8;

  // History and window sizes
  localparam int HISTORY_DEPTH = 15;
  localparam int SHORT_WINDOW = 5;
  localparam int MID_WINDOW = 10;
  localparam int LONG_WINDOW = 15;
  localparam int NUM_WIN = 3;

  // Load scale: hundredths of a percent, built from decimal quotient digits
  localparam int FULL_LOAD = 10000;
  localparam int RADIX = 10;
  localparam int DIGITS = 4;
  localparam int LOAD_W = $clog2(FULL_LOAD + 1);
  localparam int DIG_W = $clog2(RADIX + 1);
  localparam int STEP_W = $clog2(RADIX);
  localparam int DIGIT_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // History bookkeeping
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int HIDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int WIDX_W = $clog2(NUM_WIN);

  // Window sums and reciprocal multiply for the means
  localparam int SUM_W = $clog2(HISTORY_DEPTH * FULL_LOAD + 1);
  localparam int RECIP_SHIFT = SUM_W + 6;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam int WINDOW [NUM_WIN] = '{SHORT_WINDOW, MID_WINDOW, LONG_WINDOW};
  localparam logic [RECIP_W-1:0] RECIP [NUM_WIN] = '{
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + SHORT_WINDOW - 1) / SHORT_WINDOW),
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + MID_WINDOW - 1) / MID_WINDOW),
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + LONG_WINDOW - 1) / LONG_WINDOW)
  };

  localparam logic [OUT_W-1:0] NO_VALUE = {OUT_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic              capture;
    logic              calc_busy;
    logic              classify;
    logic              div_prep;
    logic              div_step;
    logic              step_last;
    logic              insert;
    logic              sum_step;
    logic [HIDX_W-1:0] sum_idx;
    logic              mul;
    logic              mean_store;
    logic [WIDX_W-1:0] win_idx;
    logic              out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy_zero;
    logic idle_ge;
  } sts_t;

endpackage

[hdl/clwa_ctrl.sv]
// Sequencing state machine for the CPU load window averager.
module clwa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  clwa_pkg::sts_t      sts,
  output clwa_pkg::cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_BUSY   = 10'b00_0000_0010,
    S_CLASS  = 10'b00_0000_0100,
    S_DPREP  = 10'b00_0000_1000,
    S_DSTEP  = 10'b00_0001_0000,
    S_INSERT = 10'b00_0010_0000,
    S_SUM    = 10'b00_0100_0000,
    S_MUL    = 10'b00_1000_0000,
    S_MSTORE = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t                             state_r, state_nxt;
  logic                               primed_r, primed_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [clwa_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic [clwa_pkg::DIGIT_CNT_W-1:0]   digit_r, digit_nxt;
  logic [clwa_pkg::HIDX_W-1:0]        idx_r, idx_nxt;
  logic [clwa_pkg::WIDX_W-1:0]        widx_r, widx_nxt;
  logic                               in_acc;
  logic                               out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // Next state, counters and commands
  always_comb begin
    state_nxt     = state_r;
    primed_nxt    = primed_r;
    step_nxt      = step_r;
    digit_nxt     = digit_r;
    idx_nxt       = idx_r;
    widx_nxt      = widx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.sum_idx   = idx_r;
    cmd.win_idx   = widx_r;
    cmd.step_last = (int'(step_r) == clwa_pkg::RADIX - 1);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          primed_nxt  = 1'b1;
          idx_nxt     = '0;
          state_nxt   = primed_r ? S_BUSY : S_SUM;
        end
      end
      S_BUSY: begin
        cmd.calc_busy = 1'b1;
        state_nxt     = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        digit_nxt    = '0;
        state_nxt    = (sts.busy_zero || sts.idle_ge) ? S_INSERT : S_DPREP;
      end
      S_DPREP: begin
        cmd.div_prep = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (cmd.step_last) begin
          if (int'(digit_r) == clwa_pkg::DIGITS - 1) begin
            state_nxt = S_INSERT;
          end else begin
            digit_nxt = digit_r + 1'b1;
            state_nxt = S_DPREP;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (int'(idx_r) == clwa_pkg::HISTORY_DEPTH - 1) begin
          widx_nxt  = '0;
          state_nxt = S_MUL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MSTORE;
      end
      S_MSTORE: begin
        cmd.mean_store = 1'b1;
        if (int'(widx_r) == clwa_pkg::NUM_WIN - 1) begin
          state_nxt = S_OUT;
        end else begin
          widx_nxt  = widx_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        // Hold the result until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      digit_r     <= '0;
      idx_r       <= '0;
      widx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      digit_r     <= digit_nxt;
      idx_r       <= idx_nxt;
      widx_r      <= widx_nxt;
    end
  end

endmodule

[hdl/clwa_dp.sv]
// Datapath: counter deltas, decimal long division, load history, window means.
module clwa_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [clwa_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  clwa_pkg::cmd_t                       cmd,
  output clwa_pkg::sts_t                       sts,
  output logic [clwa_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int W = clwa_pkg::CNT_IN_W;

  logic [W-1:0]                    prev_idle_r, prev_kernel_r, prev_user_r;
  logic [W-1:0]                    idl_r, kd_r, ud_r, busy_r;
  logic [W-1:0]                    rem_r, den_r, diff_r, acc_r;
  logic [clwa_pkg::DIG_W-1:0]      dig_r;
  logic [clwa_pkg::LOAD_W-1:0]     load_r;
  logic [clwa_pkg::LOAD_W-1:0]     hist_r [clwa_pkg::HISTORY_DEPTH];
  logic [clwa_pkg::CNT_W-1:0]      count_r;
  logic [clwa_pkg::SUM_W-1:0]      sum_r [clwa_pkg::NUM_WIN];
  logic [clwa_pkg::PROD_W-1:0]     prod_r;
  logic [clwa_pkg::LOAD_W-1:0]     mean_r [clwa_pkg::NUM_WIN];
  logic [clwa_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [W-1:0]                    in_idle, in_kernel, in_user;
  logic [W:0]                      busy_minus_idl;
  logic [W:0]                      acc_minus_diff;
  logic                            step_ge;
  logic [W-1:0]                    acc_nxt;
  logic [clwa_pkg::DIG_W-1:0]      dig_nxt;
  logic [clwa_pkg::LOAD_W-1:0]     load_digit;
  logic [clwa_pkg::SUM_W-1:0]      sum_nxt [clwa_pkg::NUM_WIN];
  logic [clwa_pkg::OUT_TDATA_W-1:0] out_data_nxt;

  assign in_idle   = in_tdata[0 +: W];
  assign in_kernel = in_tdata[W +: W];
  assign in_user   = in_tdata[2*W +: W];

  // Classify the sample
  assign busy_minus_idl = {1'b0, busy_r} - {1'b0, idl_r};
  assign sts.busy_zero  = (busy_r == '0);
  assign sts.idle_ge    = busy_minus_idl[W] || (busy_minus_idl[W-1:0] == '0);

  // One step of the decimal digit: subtract the gap or add the remainder
  assign acc_minus_diff = {1'b0, acc_r} - {1'b0, diff_r};
  assign step_ge        = !acc_minus_diff[W];
  assign acc_nxt        = step_ge ? acc_minus_diff[W-1:0] : (acc_r + rem_r);
  assign dig_nxt        = dig_r + clwa_pkg::DIG_W'(step_ge);
  assign load_digit     = clwa_pkg::LOAD_W'(int'(load_r) * clwa_pkg::RADIX + int'(dig_nxt));

  // Window sums restart at the first history entry
  always_comb begin
    for (int k = 0; k < clwa_pkg::NUM_WIN; k++) begin
      sum_nxt[k] = ((cmd.sum_idx == '0) ? '0 : sum_r[k])
                 + ((int'(cmd.sum_idx) < clwa_pkg::WINDOW[k])
                    ? clwa_pkg::SUM_W'(hist_r[0]) : '0);
    end
  end

  // Assemble the result item
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[0 +: clwa_pkg::OUT_W] = (count_r != '0)
      ? clwa_pkg::OUT_W'(hist_r[0]) : clwa_pkg::NO_VALUE;
    for (int k = 0; k < clwa_pkg::NUM_WIN; k++) begin
      out_data_nxt[(k + 1) * clwa_pkg::OUT_W +: clwa_pkg::OUT_W] =
        (clwa_pkg::WINDOW[k] != 0 && clwa_pkg::WINDOW[k] <= clwa_pkg::HISTORY_DEPTH
         && clwa_pkg::WINDOW[k] <= int'(count_r))
        ? clwa_pkg::OUT_W'(mean_r[k]) : clwa_pkg::NO_VALUE;
    end
  end

  // Count of valid loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.insert && int'(count_r) < clwa_pkg::HISTORY_DEPTH) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    // Capture deltas and remember the counters
    if (cmd.capture) begin
      idl_r         <= in_idle - prev_idle_r;
      kd_r          <= in_kernel - prev_kernel_r;
      ud_r          <= in_user - prev_user_r;
      prev_idle_r   <= in_idle;
      prev_kernel_r <= in_kernel;
      prev_user_r   <= in_user;
    end
    if (cmd.calc_busy) begin
      busy_r <= kd_r + ud_r;
    end
    // Pick a special load or start the division
    if (cmd.classify) begin
      if (sts.busy_zero) begin
        load_r <= clwa_pkg::LOAD_W'(clwa_pkg::FULL_LOAD);
      end else begin
        load_r <= '0;
      end
      rem_r <= busy_minus_idl[W-1:0];
      den_r <= busy_r;
    end
    if (cmd.div_prep) begin
      diff_r <= den_r - rem_r;
      acc_r  <= '0;
      dig_r  <= '0;
    end
    if (cmd.div_step) begin
      acc_r <= acc_nxt;
      dig_r <= dig_nxt;
      if (cmd.step_last) begin
        load_r <= load_digit;
        rem_r  <= acc_nxt;
      end
    end
    // Shift in the new load, or rotate the ring while summing
    if (cmd.insert) begin
      hist_r[0] <= load_r;
      for (int i = 1; i < clwa_pkg::HISTORY_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end else if (cmd.sum_step) begin
      hist_r[clwa_pkg::HISTORY_DEPTH-1] <= hist_r[0];
      for (int i = 0; i < clwa_pkg::HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
    end
    if (cmd.sum_step) begin
      for (int k = 0; k < clwa_pkg::NUM_WIN; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
    end
    // Mean by reciprocal multiply, one window at a time
    if (cmd.mul) begin
      prod_r <= clwa_pkg::PROD_W'(sum_r[cmd.win_idx] * clwa_pkg::RECIP[cmd.win_idx]);
    end
    if (cmd.mean_store) begin
      mean_r[cmd.win_idx] <= prod_r[clwa_pkg::RECIP_SHIFT +: clwa_pkg::LOAD_W];
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = out_data_r;

endmodule

[hdl/cpu_load_window_averager.sv]
// Top level of the CPU load window averager: controller, datapath and checks.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | idle_total, kernel_total, user_total
//  out_    | out | out_tvalid/out_tready | current_load, mean_short, mean_mid,
//          |     |                     | mean_long
//
// An item that needs the division goes from accept through output load via the deltas and
// classification, the long division (4 digits, each from 64-bit compare and subtract steps),
// the insert, the sum over the history ring, the three reciprocal multiplies and the load.
// The first item skips classification, division and insert; a special load skips division.
// A waiting result does not block input; a stalled output holds the next item at its
// last stage. Synchronous reset clears state, primed flag, load count and output valid.
module cpu_load_window_averager (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // idle_total [63:0], kernel_total [127:64], user_total [191:128]
  input  logic [clwa_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // current_load [14:0], mean_short [29:15], mean_mid [44:30], mean_long [59:45]
  output logic [clwa_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  clwa_pkg::cmd_t cmd;
  clwa_pkg::sts_t sts;

  clwa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  clwa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

`ifndef ASSERT_OFF
  // Only one datapath operation per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.calc_busy, cmd.classify, cmd.div_prep, cmd.div_step,
              cmd.insert, cmd.sum_step, cmd.mul, cmd.mean_store, cmd.out_load}))
    else $error("more than one datapath command active");

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

  // An accepted item does not produce its result in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !cmd.out_load)
    else $error("result loaded right after accept");
`endif

endmodule
